@@ src/free_list_index_allocator_top_macros.svh @@
// assertion macros for the slot allocator
`ifndef FREE_LIST_INDEX_ALLOCATOR_TOP_MACROS_SVH
`define FREE_LIST_INDEX_ALLOCATOR_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define FLA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("allocator check failed");

// antecedent implies consequent in the next cycle
`define FLA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

@@ src/fla_pkg.sv @@
package fla_pkg;

    localparam int IDX_W         = 11;
    localparam int ST_W          = 3;
    localparam int SLOTS_DEFAULT = 2048;
    localparam int IN_TDATA_W    = ((IDX_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = ((IDX_W + 7) / 8) * 8;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [ST_W-1:0] {
        ST_REUSED = 3'd0,
        ST_FRESH  = 3'd1,
        ST_FULL   = 3'd2,
        ST_FREED  = 3'd3,
        ST_BAD    = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } fla_cmd_t;

endpackage

@@ src/fla_ram.sv @@
module fla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/fla_ctrl.sv @@
module fla_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output fla_pkg::fla_cmd_t cmd
);

    import fla_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        s_tready      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                // wait for the output register to free up
                if (!m_tvalid_reg || m_tready) begin
                    cmd.commit    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

@@ src/fla_dp.sv @@
module fla_dp #(
    parameter int SLOTS = fla_pkg::SLOTS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  fla_pkg::fla_cmd_t        cmd,
    input  logic                     in_action,
    input  logic [fla_pkg::IDX_W-1:0] in_index,
    output logic [fla_pkg::IDX_W-1:0] out_granted,
    output fla_pkg::status_t         out_status
);

    import fla_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int HW = AW + 1;
    localparam int CW = (HW > IDX_W) ? HW : IDX_W;
    localparam int DW = AW + 2;
    localparam logic [HW-1:0] SLOTS_HW = HW'(SLOTS);

    // entry layout: removed flag, link valid, next link
    logic [AW-1:0] head_reg, head_next;
    logic          nonempty_reg, nonempty_next;
    logic [HW-1:0] hw_reg, hw_next;
    logic          act_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] granted_reg, granted_next;
    status_t       status_reg, status_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_data;
    logic [AW-1:0] idx_addr;
    logic          idx_ok;

    fla_ram #(
        .WIDTH(DW),
        .DEPTH(SLOTS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.capture),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_addr  = (in_action == ACT_FREE) ? AW'(in_index) : head_reg;
    assign idx_addr = AW'(idx_reg);
    assign idx_ok   = CW'(idx_reg) < CW'(hw_reg);

    always_comb begin
        head_next     = head_reg;
        nonempty_next = nonempty_reg;
        hw_next       = hw_reg;
        granted_next  = '0;
        status_next   = ST_FULL;
        wr_en         = 1'b0;
        wr_addr       = head_reg;
        wr_data       = '0;
        if (act_reg == ACT_ALLOC) begin
            if (nonempty_reg) begin
                granted_next  = IDX_W'(head_reg);
                status_next   = ST_REUSED;
                wr_en         = cmd.commit;
                nonempty_next = rd_data[AW];
                head_next     = rd_data[AW] ? rd_data[AW-1:0] : '0;
            end else if (hw_reg != SLOTS_HW) begin
                // fresh slot gets its removed flag written clear here
                granted_next = IDX_W'(hw_reg);
                status_next  = ST_FRESH;
                wr_en        = cmd.commit;
                wr_addr      = AW'(hw_reg);
                hw_next      = hw_reg + HW'(1);
            end
        end else begin
            if (!idx_ok || rd_data[AW+1]) begin
                status_next = ST_BAD;
            end else begin
                status_next   = ST_FREED;
                wr_en         = cmd.commit;
                wr_addr       = idx_addr;
                wr_data       = {1'b1, nonempty_reg, head_reg};
                head_next     = idx_addr;
                nonempty_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            nonempty_reg <= 1'b0;
            hw_reg       <= '0;
        end else if (cmd.commit) begin
            head_reg     <= head_next;
            nonempty_reg <= nonempty_next;
            hw_reg       <= hw_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg <= in_action;
            idx_reg <= in_index;
        end
        if (cmd.commit) begin
            granted_reg <= granted_next;
            status_reg  <= status_next;
        end
    end

    assign out_granted = granted_reg;
    assign out_status  = status_reg;

endmodule

@@ src/free_list_index_allocator_top.sv @@
// Slot allocator with stable indices and a LIFO free list of released slots.
// Input channel s_*: s_tuser is the request (0 allocate, 1 free) and
// s_tdata[10:0] the slot to free, ignored on allocate.
// Result channel m_*: m_tdata[10:0] is the granted slot (zero unless an
// allocate succeeds) and m_tuser the status: 0 reused, 1 fresh, 2 full,
// 3 freed, 4 double free or invalid slot. Every request gives one result.
// A request is captured in the idle state and committed in the exec state, and
// no new request is taken until the previous one has committed; the free
// list link and removed flag live in one synchronous RAM whose read lands in
// the cycle after acceptance, and the list update waits on that read.
// A new request is taken while an earlier result still waits on m_tready;
// if the receiver stalls, the next result is held until the output register
// drains and no further request is taken meanwhile.
// Reset (aresetn low, synchronous) empties the list and the high-water mark
// at once; the RAM needs no clearing pass, as each entry is written when its
// slot is first handed out.
`include "free_list_index_allocator_top_macros.svh"

module free_list_index_allocator_top #(
    parameter int SLOTS = fla_pkg::SLOTS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fla_pkg::IN_TDATA_W-1:0]  s_tdata,  // slot_index, zero pad
    input  logic                            s_tuser,  // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fla_pkg::OUT_TDATA_W-1:0] m_tdata,  // granted_index, zero pad
    output logic [fla_pkg::ST_W-1:0]        m_tuser   // status
);

    import fla_pkg::*;

    fla_cmd_t         cmd;
    logic [IDX_W-1:0] granted;
    status_t          status;

    fla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    fla_dp #(
        .SLOTS(SLOTS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_action   (s_tuser),
        .in_index    (s_tdata[IDX_W-1:0]),
        .out_granted (granted),
        .out_status  (status)
    );

    assign m_tdata = OUT_TDATA_W'(granted);
    assign m_tuser = status;

    `FLA_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
    `FLA_ASSERT_NOW(a_commit_not_accept, cmd.commit, !s_tready)
    `FLA_ASSERT_NEXT(a_commit_shows, cmd.commit, m_tvalid)
    `FLA_ASSERT_NOW(a_status_code, m_tvalid, m_tuser <= ST_BAD)

endmodule
